// ===== src/rtnh_pkg.sv =====
// ============================================================================
// rtnh_pkg - route table next hop resolver shared definitions
// Request and result transaction types, request codes and status codes.
// ============================================================================
`default_nettype none

package rtnh_pkg;

	localparam int ENTRIES_DEF   = 32;
	localparam int ADDR_BITS_DEF = 32;
	localparam int MAX_HOPS_DEF  = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_REMOVE  = 3'd1;
	localparam logic [2:0] REQ_LOOKUP  = 3'd2;
	localparam logic [2:0] REQ_RESOLVE = 3'd3;
	localparam logic [2:0] REQ_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_HOP_LIMIT = 2'd3;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_LOOKUP,
		OP_RESOLVE,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] route_dest;
		logic [31:0] route_next;
		logic [31:0] route_iface;
		logic [7:0]  hop_distance;
		logic [3:0]  iface_index;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_dest;
		logic [31:0] found_next;
		logic [31:0] found_iface;
		logic [7:0]  found_distance;
		logic [3:0]  found_index;
		logic [5:0]  entry_count;
	} out_t;

	typedef struct packed {
		op_t op;
		in_t req;
	} q_item_t;

endpackage

`default_nettype wire

// ===== src/route_table_next_hop_resolver.sv =====
// ============================================================================
// route_table_next_hop_resolver - exact match route table with resolve
// Top level: request intake, queue and table engine.
// ============================================================================
// Each request transaction is decoded and queued by the front end, then run
// by the engine one at a time. Insert, remove, clear and unknown requests
// take the engine steps pop, key match over all slots and update; lookup
// adds the registered payload memory read. Resolve repeats the key
// match and the payload memory read for each link followed, up to MAX_HOPS
// links. The two-deep queue keeps taking requests while a result waits in
// the output register. No clearing pass is needed after reset: slot valid
// bits reset at once.
// ============================================================================
`default_nettype none

module route_table_next_hop_resolver #(
	parameter int ENTRIES   = rtnh_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = rtnh_pkg::ADDR_BITS_DEF,
	parameter int MAX_HOPS  = rtnh_pkg::MAX_HOPS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire rtnh_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output rtnh_pkg::out_t      out_data
);

	logic              q_valid;
	logic              q_pop;
	rtnh_pkg::q_item_t q_item;

	// decode and buffer requests
	rtnh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// table engine with result register
	rtnh_back #(
		.ENTRIES   (ENTRIES),
		.ADDR_BITS (ADDR_BITS),
		.MAX_HOPS  (MAX_HOPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== src/rtnh_front.sv =====
// ============================================================================
// rtnh_front - request intake
// Accepts request transactions, decodes the request type and queues them.
// ============================================================================
`default_nettype none

module rtnh_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire rtnh_pkg::in_t   in_data,
	output logic                 q_valid,
	output rtnh_pkg::q_item_t    q_item,
	input  wire logic            q_pop
);

	localparam int DEPTH = rtnh_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtnh_pkg::q_item_t     fifo_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      cnt_q;
	rtnh_pkg::op_t         op;
	logic                  push;

	always_comb begin
		unique case (in_data.req_type)
			rtnh_pkg::REQ_INSERT:  op = rtnh_pkg::OP_INSERT;
			rtnh_pkg::REQ_REMOVE:  op = rtnh_pkg::OP_REMOVE;
			rtnh_pkg::REQ_LOOKUP:  op = rtnh_pkg::OP_LOOKUP;
			rtnh_pkg::REQ_RESOLVE: op = rtnh_pkg::OP_RESOLVE;
			rtnh_pkg::REQ_CLEAR:   op = rtnh_pkg::OP_CLEAR;
			default:               op = rtnh_pkg::OP_NOP;
		endcase
	end

	assign in_stall = (cnt_q == CNT_W'(DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{op: op, req: in_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/rtnh_back.sv =====
// ============================================================================
// rtnh_back - route table engine
// Parallel key match, payload memory, resolve chase and result register.
// ============================================================================
`default_nettype none

module rtnh_back #(
	parameter int ENTRIES   = rtnh_pkg::ENTRIES_DEF,
	parameter int ADDR_BITS = rtnh_pkg::ADDR_BITS_DEF,
	parameter int MAX_HOPS  = rtnh_pkg::MAX_HOPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire rtnh_pkg::q_item_t q_item,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rtnh_pkg::out_t         out_data
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int HOP_W = $clog2(MAX_HOPS + 1);

	typedef struct packed {
		logic [ADDR_BITS-1:0] next_hop;
		logic [ADDR_BITS-1:0] iface;
		logic [7:0]           distance;
		logic [3:0]           index;
	} slot_t;

	typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_ACT, S_READ} state_t;

	slot_t                mem [ENTRIES];
	logic [ADDR_BITS-1:0] key_tab_q [ENTRIES];
	slot_t                rd_q;
	logic [ENTRIES-1:0]   valid_q;
	logic [CNT_W-1:0]     cnt_q;
	state_t               state_q;
	rtnh_pkg::q_item_t    item_q;
	logic [ADDR_BITS-1:0] key_q;
	logic [HOP_W-1:0]     hops_q;
	logic                 hit_q, free_q;
	logic [IDX_W-1:0]     hit_idx_q, free_idx_q;
	logic                 out_valid_q;
	rtnh_pkg::out_t       out_q;

	logic                 hit, free;
	logic [IDX_W-1:0]     hit_idx, free_idx;
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr;
	slot_t                mem_wdata;
	slot_t                ins_slot;

	// lowest matching and lowest free slot
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free     = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_tab_q[i] == key_q) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free     = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign ins_slot.next_hop = ADDR_BITS'(item_q.req.route_next);
	assign ins_slot.iface    = ADDR_BITS'(item_q.req.route_iface);
	assign ins_slot.distance = item_q.req.hop_distance;
	assign ins_slot.index    = item_q.req.iface_index;

	assign mem_we    = (state_q == S_ACT) && (item_q.op == rtnh_pkg::OP_INSERT)
		&& (hit_q || free_q);
	assign mem_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign mem_wdata = ins_slot;
	assign mem_re    = (state_q == S_ACT) && hit_q
		&& (item_q.op == rtnh_pkg::OP_LOOKUP || item_q.op == rtnh_pkg::OP_RESOLVE);

	assign q_pop     = (state_q == S_IDLE) && q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr]       <= mem_wdata;
			key_tab_q[mem_waddr] <= key_q;
		end
		if (mem_re) begin
			rd_q <= mem[hit_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			item_q      <= '0;
			key_q       <= '0;
			hops_q      <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			hit_idx_q   <= '0;
			free_idx_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						item_q  <= q_item;
						key_q   <= ADDR_BITS'(q_item.req.route_dest);
						hops_q  <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					hit_q      <= hit;
					hit_idx_q  <= hit_idx;
					free_q     <= free;
					free_idx_q <= free_idx;
					state_q    <= S_ACT;
				end
				S_ACT: begin
					out_q.status      <= rtnh_pkg::ST_OK;
					out_q.found_dest  <= '0;
					out_q.found_next  <= '0;
					out_q.found_iface <= '0;
					out_q.found_distance <= '0;
					out_q.found_index <= '0;
					out_q.entry_count <= 6'(cnt_q);
					state_q           <= S_IDLE;
					out_valid_q       <= 1'b1;
					unique case (item_q.op)
						rtnh_pkg::OP_INSERT: begin
							if (hit_q || free_q) begin
								out_q.found_dest     <= 32'(key_q);
								out_q.found_next     <= 32'(ins_slot.next_hop);
								out_q.found_iface    <= 32'(ins_slot.iface);
								out_q.found_distance <= ins_slot.distance;
								out_q.found_index    <= ins_slot.index;
							end else begin
								out_q.status <= rtnh_pkg::ST_FULL;
							end
							if (!hit_q && free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								cnt_q               <= cnt_q + 1'b1;
								out_q.entry_count   <= 6'(cnt_q + 1'b1);
							end
						end
						rtnh_pkg::OP_REMOVE: begin
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								cnt_q              <= cnt_q - 1'b1;
								out_q.entry_count  <= 6'(cnt_q - 1'b1);
							end else begin
								out_q.status <= rtnh_pkg::ST_NOT_FOUND;
							end
						end
						rtnh_pkg::OP_LOOKUP, rtnh_pkg::OP_RESOLVE: begin
							if (hit_q) begin
								out_valid_q <= 1'b0;
								state_q     <= S_READ;
							end else begin
								out_q.status <= rtnh_pkg::ST_NOT_FOUND;
							end
						end
						rtnh_pkg::OP_CLEAR: begin
							valid_q           <= '0;
							cnt_q             <= '0;
							out_q.entry_count <= '0;
						end
						default: begin
						end
					endcase
				end
				S_READ: begin
					// slot dest equals key_q on every hit
					if (item_q.op == rtnh_pkg::OP_RESOLVE && rd_q.next_hop != key_q
						&& hops_q != HOP_W'(MAX_HOPS)) begin
						key_q   <= rd_q.next_hop;
						hops_q  <= hops_q + 1'b1;
						state_q <= S_SEARCH;
					end else begin
						if (item_q.op == rtnh_pkg::OP_RESOLVE && rd_q.next_hop != key_q) begin
							out_q.status <= rtnh_pkg::ST_HOP_LIMIT;
						end else begin
							out_q.found_dest     <= 32'(key_q);
							out_q.found_next     <= 32'(rd_q.next_hop);
							out_q.found_iface    <= 32'(rd_q.iface);
							out_q.found_distance <= rd_q.distance;
							out_q.found_index    <= rd_q.index;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/rtnh_checker.sv =====
// ============================================================================
// rtnh_checker - port level checks
// Result channel behaviour and status consistency.
// ============================================================================
`default_nettype none

module rtnh_checker #(
	parameter int ENTRIES = rtnh_pkg::ENTRIES_DEF
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           out_valid,
	input wire logic           out_stall,
	input wire rtnh_pkg::out_t out_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == rtnh_pkg::ST_FULL
		|-> out_data.entry_count == 6'(ENTRIES))
		else $error("table full reported below capacity");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != rtnh_pkg::ST_OK
		|-> out_data.found_dest == '0 && out_data.found_next == '0
			&& out_data.found_iface == '0 && out_data.found_distance == '0
			&& out_data.found_index == '0)
		else $error("entry fields set on failed transaction");

endmodule

bind route_table_next_hop_resolver rtnh_checker #(.ENTRIES(ENTRIES)) u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
